// File: design/abt_pkg.sv
package abt_pkg;

  // table geometry
  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);

  // field widths
  localparam int OP_W    = 3;
  localparam int SENS_W  = 10;
  localparam int EIDX_W  = 4;
  localparam int LEVEL_W = 8;
  localparam int PWM_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  // sensor scaling: product of reading and (entries - 2), divided by full scale
  localparam int PROD_W = SENS_W + IDX_W;

  // level limits
  localparam logic [LEVEL_W-1:0] BOOST_LEVEL  = LEVEL_W'(100);
  localparam logic [LEVEL_W-1:0] PWM_MAX      = LEVEL_W'(99);
  localparam logic [LEVEL_W-1:0] BOOST_OFFSET = LEVEL_W'(34);
  localparam logic [LEVEL_W-1:0] TOP_LEVEL    = LEVEL_W'(133);
  localparam int STEP_MIN = 1;
  localparam int STEP_MAX = 4;

  // op codes
  localparam logic [OP_W-1:0] OP_SENSOR   = 3'd0;
  localparam logic [OP_W-1:0] OP_INC      = 3'd1;
  localparam logic [OP_W-1:0] OP_DEC      = 3'd2;
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd3;
  localparam logic [OP_W-1:0] OP_READ     = 3'd4;
  localparam logic [OP_W-1:0] OP_BOOSTOFF = 3'd5;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_AUTO  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOOST = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DIV,
    S_DOWN,
    S_UP,
    S_DRIVE,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    STEP_INC,
    STEP_DEC,
    STEP_DOWN,
    STEP_UP
  } step_mode_t;

  typedef struct packed {
    step_mode_t         mode;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W-1:0] neighbor;
    logic               boost_en;
  } step_req_t;

endpackage

// File: design/adaptive_brightness_table_top.sv
// adaptive brightness table: a 16-entry table of display levels (0..133) picked by
// ambient light. a request carries an op: sensor update (selects entry
// reading*(entries-2)/1023+1 in auto mode, entry 0 otherwise), increase, decrease,
// load entry, read entry and boost off. each request yields exactly one result with
// pwm_level, boost_on and entry_value. the block takes one request at a time and
// holds in_stall high until the request is done; the finished result waits in an
// output register, so the next request can be taken while it is still stalled.
// states from acceptance to the output register: exec, fin for load, read, boost
// off and unused codes; exec, drive, fin for a sensor update with auto off and
// exec, div, drive, fin with auto on (exec registers the scaling multiply, div
// applies the divide-by-1023 correction). increase and decrease pass exec, drive,
// fin with auto off; with auto on the reshaping walk visits entries 1 through the
// last, skipping the current one, one entry per cycle through the shared step
// unit. the table comes out of reset as all 99 with no clearing pass. configuration
// is written through cfg_we/cfg_index/cfg_data while the block is idle, a rule
// for the user that the block does not enforce: index 0 auto_enable (writing 0
// also selects entry 0), index 1 boost_enable (writing 0 also drops boost_on).
module adaptive_brightness_table_top (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [abt_pkg::OP_W-1:0]          op,
  input  logic [abt_pkg::SENS_W-1:0]        sensor_value,
  input  logic [abt_pkg::EIDX_W-1:0]        entry_index,
  input  logic [abt_pkg::LEVEL_W-1:0]       entry_level,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [abt_pkg::PWM_W-1:0]         pwm_level,
  output logic                              boost_on,
  output logic [abt_pkg::LEVEL_W-1:0]       entry_value,
  // configuration port
  input  logic                              cfg_we,
  input  logic [abt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [abt_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import abt_pkg::*;

  // sequencer
  state_t state;
  state_t state_next;

  // configuration and control state
  logic             auto_en;
  logic             boost_en;
  logic             boost_pin;
  logic [IDX_W-1:0] cur;

  // latched request
  logic [OP_W-1:0]    op_r;
  logic [SENS_W-1:0]  sensor_r;
  logic [EIDX_W-1:0]  eidx_r;
  logic [LEVEL_W-1:0] elev_r;

  // working registers
  logic [PROD_W-1:0]  prod;
  logic [IDX_W-1:0]   walk;
  logic [LEVEL_W-1:0] prev;
  logic [LEVEL_W-1:0] cur_level;
  logic [PWM_W-1:0]   res_pwm;
  logic [LEVEL_W-1:0] res_ev;

  // level table, one write and one read address per cycle
  logic [LEVEL_W-1:0] level_table [TABLE_ENTRIES];
  logic               tbl_we;
  logic [IDX_W-1:0]   tbl_wa;
  logic [LEVEL_W-1:0] tbl_wd;
  logic [IDX_W-1:0]   rd_addr;
  logic [LEVEL_W-1:0] rd_data;

  // request fields decoded
  logic [IDX_W-1:0] eidx_addr;
  logic             eidx_ok;
  logic             accept;
  logic             out_free;

  // shared step unit
  step_req_t          step_req;
  logic [LEVEL_W-1:0] step_res;

  // divide-by-1023 correction
  logic [IDX_W-1:0]  q0;
  logic [SENS_W:0]   rem;
  logic [IDX_W:0]    idx_full;
  logic [IDX_W-1:0]  sensor_idx;

  // drive mapping
  logic [PWM_W-1:0] drv_pwm;
  logic             drv_high;

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
  localparam logic [IDX_W-1:0] IDX_ONE  = IDX_W'(1);
  localparam logic [SENS_W:0]  SENS_FULL = (SENS_W+1)'((1 << SENS_W) - 1);

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  assign eidx_addr = IDX_W'(eidx_r);
  assign eidx_ok   = (int'(eidx_r) < TABLE_ENTRIES);

  // x/1023 with x = 1024*q0 + t: remainder is t + q0, below twice 1023
  assign q0  = prod[PROD_W-1:SENS_W];
  assign rem = (SENS_W+1)'(prod[SENS_W-1:0]) + (SENS_W+1)'(q0);
  always_comb begin
    idx_full = (IDX_W+1)'(q0) + (IDX_W+1)'(1);
    if (rem >= SENS_FULL) idx_full = idx_full + (IDX_W+1)'(1);
    if (int'(idx_full) >= TABLE_ENTRIES) sensor_idx = LAST_IDX;
    else sensor_idx = idx_full[IDX_W-1:0];
  end

  // table read mux
  always_comb begin
    unique case (state)
      S_EXEC:        rd_addr = (op_r == OP_READ) ? eidx_addr : cur;
      S_DOWN, S_UP:  rd_addr = walk;
      default:       rd_addr = cur;
    endcase
  end
  assign rd_data = level_table[rd_addr];

  // step unit request
  always_comb begin
    step_req.level    = rd_data;
    step_req.neighbor = prev;
    step_req.boost_en = boost_en;
    unique case (state)
      S_DOWN:  step_req.mode = STEP_DOWN;
      S_UP:    step_req.mode = STEP_UP;
      default: step_req.mode = (op_r == OP_DEC) ? STEP_DEC : STEP_INC;
    endcase
  end

  abt_step_unit u_step (
    .req    (step_req),
    .result (step_res)
  );

  // level to drive step; with boost enabled high levels go through the boost output, else they drive 99
  always_comb begin
    drv_high = (rd_data >= BOOST_LEVEL);
    if (boost_en) begin
      drv_pwm = drv_high ? PWM_W'(rd_data - BOOST_OFFSET) : rd_data[PWM_W-1:0];
    end else begin
      drv_pwm = drv_high ? PWM_MAX[PWM_W-1:0] : rd_data[PWM_W-1:0];
    end
  end

  // sequencer next state and table write
  always_comb begin
    state_next = state;
    tbl_we     = 1'b0;
    tbl_wa     = cur;
    tbl_wd     = step_res;
    unique case (state)
      S_IDLE: begin
        if (accept) state_next = S_EXEC;
      end
      S_EXEC: begin
        priority case (op_r)
          OP_SENSOR: state_next = auto_en ? S_DIV : S_DRIVE;
          OP_INC, OP_DEC: begin
            tbl_we = 1'b1;
            if (!auto_en) state_next = S_DRIVE;
            else if (int'(cur) >= 2) state_next = S_DOWN;
            else if (cur != LAST_IDX) state_next = S_UP;
            else state_next = S_DRIVE;
          end
          OP_LOAD: begin
            tbl_we     = eidx_ok;
            tbl_wa     = eidx_addr;
            tbl_wd     = (elev_r > TOP_LEVEL) ? TOP_LEVEL : elev_r;
            state_next = S_FIN;
          end
          default: state_next = S_FIN;
        endcase
      end
      S_DIV: state_next = S_DRIVE;
      S_DOWN: begin
        tbl_we = 1'b1;
        tbl_wa = walk;
        if (walk == IDX_ONE) state_next = (cur != LAST_IDX) ? S_UP : S_DRIVE;
      end
      S_UP: begin
        tbl_we = 1'b1;
        tbl_wa = walk;
        if (walk == LAST_IDX) state_next = S_DRIVE;
      end
      S_DRIVE: state_next = S_FIN;
      S_FIN: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // table storage
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) level_table[i] <= PWM_MAX;
    end else if (tbl_we) begin
      level_table[tbl_wa] <= tbl_wd;
    end
  end

  // request latch and working registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op;
      sensor_r <= sensor_value;
      eidx_r   <= entry_index;
      elev_r   <= entry_level;
    end
    unique case (state)
      S_EXEC: begin
        prod      <= PROD_W'(sensor_r) * PROD_W'(TABLE_ENTRIES - 2);
        res_pwm   <= '0;
        res_ev    <= (op_r == OP_READ && eidx_ok) ? rd_data : '0;
        prev      <= step_res;
        cur_level <= step_res;
        walk      <= (int'(cur) >= 2) ? cur - IDX_ONE : cur + IDX_ONE;
      end
      S_DOWN: begin
        if (walk == IDX_ONE) begin
          prev <= cur_level;
          walk <= cur + IDX_ONE;
        end else begin
          prev <= step_res;
          walk <= walk - IDX_ONE;
        end
      end
      S_UP: begin
        prev <= step_res;
        walk <= walk + IDX_ONE;
      end
      S_DRIVE: res_pwm <= drv_pwm;
      default: ;
    endcase
  end

  // control state: current entry, boost output, configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      cur       <= '0;
      boost_pin <= 1'b0;
      auto_en   <= 1'b0;
      boost_en  <= 1'b0;
    end else begin
      if (state == S_EXEC && op_r == OP_SENSOR && !auto_en) cur <= '0;
      if (state == S_DIV) cur <= sensor_idx;
      if (state == S_DRIVE && boost_en) boost_pin <= drv_high;
      if (state == S_EXEC && op_r == OP_BOOSTOFF && boost_en) boost_pin <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_AUTO: begin
            auto_en <= cfg_data[0];
            if (!cfg_data[0]) cur <= '0;
          end
          CFG_BOOST: begin
            boost_en <= cfg_data[0];
            if (!cfg_data[0]) boost_pin <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && out_free) begin
      pwm_level   <= res_pwm;
      boost_on    <= boost_pin;
      entry_value <= res_ev;
    end
  end

  // a new result enters the output register only from the final step
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FIN))
    else $error("result appeared outside the final step");

  // the downward walk stays between entry 1 and the entry below the current one
  a_down_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_DOWN) |-> (walk != '0 && walk < cur))
    else $error("downward walk out of range");

  // the upward walk stays above the current entry
  a_up_walk_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_UP) |-> (walk > cur))
    else $error("upward walk out of range");

  // nothing above the top level is ever stored
  a_table_write_cap: assert property (@(posedge clk) disable iff (rst)
    tbl_we |-> (tbl_wd <= TOP_LEVEL))
    else $error("table write above top level");

  // drive step never exceeds 99
  a_pwm_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pwm_level <= PWM_MAX[PWM_W-1:0]))
    else $error("pwm level out of range");

endmodule

// File: design/abt_step_unit.sv
module abt_step_unit (
  input  abt_pkg::step_req_t        req,
  output logic [abt_pkg::LEVEL_W-1:0] result
);
  import abt_pkg::*;

  localparam int W = LEVEL_W + 2;

  logic signed [W-1:0] lvl;
  logic signed [W-1:0] nb;
  logic signed [W-1:0] lo;
  logic signed [W-1:0] hi;
  logic signed [W-1:0] v;

  always_comb begin
    lvl = signed'(W'(req.level));
    nb  = signed'(W'(req.neighbor));
    lo  = '0;
    hi  = '0;
    v   = lvl;
    unique case (req.mode)
      STEP_INC: begin
        v = lvl + W'(1);
        if (req.boost_en) begin
          if (v > signed'(W'(TOP_LEVEL))) v = signed'(W'(TOP_LEVEL));
        end else begin
          if (v >= signed'(W'(BOOST_LEVEL))) v = signed'(W'(PWM_MAX));
        end
      end
      STEP_DEC: begin
        v = lvl - W'(1);
        if (v < 0) v = '0;
      end
      STEP_DOWN: begin
        // entries below the current one sit 1..4 above their upper neighbor, capped at the top level
        lo = nb + W'(STEP_MIN);
        hi = nb + W'(STEP_MAX);
        if (v < lo) v = lo;
        if (v > hi) v = hi;
        if (v > signed'(W'(TOP_LEVEL))) v = signed'(W'(TOP_LEVEL));
      end
      STEP_UP: begin
        // entries above sit 1..4 below their lower neighbor, floored at 0
        lo = nb - W'(STEP_MAX);
        hi = nb - W'(STEP_MIN);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        if (v < 0) v = '0;
      end
      default: v = lvl;
    endcase
  end

  assign result = v[LEVEL_W-1:0];

endmodule

// File: sim/brightness_checker.sv
module brightness_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [abt_pkg::OP_W-1:0]      op,
  input  logic [abt_pkg::SENS_W-1:0]    sensor_value,
  input  logic [abt_pkg::EIDX_W-1:0]    entry_index,
  input  logic [abt_pkg::LEVEL_W-1:0]   entry_level,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [abt_pkg::PWM_W-1:0]     pwm_level,
  input  logic                          boost_on,
  input  logic [abt_pkg::LEVEL_W-1:0]   entry_value,
  input  logic                          cfg_we,
  input  logic [abt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [abt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                            mismatches,
  output int                            pending,
  output int                            checked
);
  import abt_pkg::*;

  localparam int SENSOR_FULL = 1023;

  typedef struct packed {
    logic [PWM_W-1:0]   pwm;
    logic               boost;
    logic [LEVEL_W-1:0] entry;
  } brightness_t;

  logic [LEVEL_W-1:0] levels [TABLE_ENTRIES];
  int                 sel_index;
  logic               boost_pin_q;
  logic               auto_en;
  logic               boost_en;
  brightness_t        expected_q [$];
  brightness_t        want;
  logic               bad;

  // levels of 100 and up go through the boost output when it is allowed
  function automatic int drive_pwm(input int lvl);
    if (boost_en) begin
      if (lvl >= int'(BOOST_LEVEL)) begin
        boost_pin_q = 1'b1;
        return lvl - int'(BOOST_OFFSET);
      end
      boost_pin_q = 1'b0;
      return lvl;
    end
    return (lvl >= int'(BOOST_LEVEL)) ? int'(PWM_MAX) : lvl;
  endfunction

  // entries below the selected one climb, entries above fall, 1..4 per step
  function automatic void reshape_levels();
    int i;
    int v;
    int p;
    for (i = sel_index - 1; i >= 1; i--) begin
      v = int'(levels[i]);
      p = int'(levels[i+1]);
      if (v < p + STEP_MIN) v = p + STEP_MIN;
      if (v > p + STEP_MAX) v = p + STEP_MAX;
      if (v > int'(TOP_LEVEL)) v = int'(TOP_LEVEL);
      levels[i] = v[LEVEL_W-1:0];
    end
    for (i = sel_index + 1; i < TABLE_ENTRIES; i++) begin
      v = int'(levels[i]);
      p = int'(levels[i-1]);
      if (v > p - STEP_MIN) v = p - STEP_MIN;
      if (v < p - STEP_MAX) v = p - STEP_MAX;
      if (v < 0) v = 0;
      levels[i] = v[LEVEL_W-1:0];
    end
  endfunction

  function automatic brightness_t predict_request(
    input logic [OP_W-1:0]    code,
    input logic [SENS_W-1:0]  sens,
    input logic [EIDX_W-1:0]  idx,
    input logic [LEVEL_W-1:0] lvl
  );
    brightness_t r;
    int          v;
    int          pwm;
    int          ev;
    pwm = 0;
    ev  = 0;
    if (sel_index >= TABLE_ENTRIES) sel_index = 0;
    case (code)
      OP_SENSOR: begin
        if (auto_en) sel_index = int'(sens) * (TABLE_ENTRIES - 2) / SENSOR_FULL + 1;
        else sel_index = 0;
        if (sel_index >= TABLE_ENTRIES) sel_index = TABLE_ENTRIES - 1;
        pwm = drive_pwm(int'(levels[sel_index]));
      end
      OP_INC: begin
        v = int'(levels[sel_index]) + 1;
        if (boost_en) begin
          if (v > int'(TOP_LEVEL)) v = int'(TOP_LEVEL);
        end else if (v >= int'(BOOST_LEVEL)) begin
          v = int'(PWM_MAX);
        end
        levels[sel_index] = v[LEVEL_W-1:0];
        if (auto_en) reshape_levels();
        pwm = drive_pwm(int'(levels[sel_index]));
      end
      OP_DEC: begin
        v = int'(levels[sel_index]) - 1;
        if (v < 0) v = 0;
        levels[sel_index] = v[LEVEL_W-1:0];
        if (auto_en) reshape_levels();
        pwm = drive_pwm(int'(levels[sel_index]));
      end
      OP_LOAD: begin
        if (int'(idx) < TABLE_ENTRIES) levels[idx] = (lvl > TOP_LEVEL) ? TOP_LEVEL : lvl;
      end
      OP_READ: begin
        if (int'(idx) < TABLE_ENTRIES) ev = int'(levels[idx]);
      end
      OP_BOOSTOFF: begin
        if (boost_en) boost_pin_q = 1'b0;
      end
      default: ;
    endcase
    r.pwm   = pwm[PWM_W-1:0];
    r.boost = boost_pin_q;
    r.entry = ev[LEVEL_W-1:0];
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (levels[i]) levels[i] = PWM_MAX;
      sel_index   = 0;
      boost_pin_q = 1'b0;
      auto_en     = 1'b0;
      boost_en    = 1'b0;
      expected_q.delete();
      mismatches <= 0;
      pending    <= 0;
      checked    <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_AUTO: begin
            auto_en = cfg_data[0];
            if (!auto_en) sel_index = 0;
          end
          CFG_BOOST: begin
            boost_en = cfg_data[0];
            if (!boost_en) boost_pin_q = 1'b0;
          end
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_q.push_back(predict_request(op, sensor_value, entry_index, entry_level));
      if (out_valid && !out_stall) begin
        bad = 1'b0;
        if (expected_q.size() == 0) begin
          $error("result arrived with no request outstanding");
          bad = 1'b1;
        end else begin
          want = expected_q.pop_front();
          if (pwm_level !== want.pwm) begin
            $error("pwm_level: expected %0d, actual %0d", want.pwm, pwm_level);
            bad = 1'b1;
          end
          if (boost_on !== want.boost) begin
            $error("boost_on: expected %0d, actual %0d", want.boost, boost_on);
            bad = 1'b1;
          end
          if (entry_value !== want.entry) begin
            $error("entry_value: expected %0d, actual %0d", want.entry, entry_value);
            bad = 1'b1;
          end
          checked <= checked + 1;
        end
        if (bad) mismatches <= mismatches + 1;
      end
      pending <= expected_q.size();
    end
  end

endmodule

// File: sim/adaptive_brightness_table_top_tb.sv
module adaptive_brightness_table_top_tb;
  import abt_pkg::*;

  // spare op codes the block must answer with zero pwm_level and entry_value
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam int PHASES          = 6;
  localparam int PHASE_REQUESTS  = 100;
  localparam int HOLD_OFF_AT     = 200;   // results taken before the long stall
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 24;    // covers the longest reshaping walk
  localparam int WATCHDOG_LIMIT  = 2000;

  // auto/boost setting per random phase, bit p belongs to phase p
  localparam logic [PHASES-1:0] PHASE_AUTO  = 6'b110101;
  localparam logic [PHASES-1:0] PHASE_BOOST = 6'b011001;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [OP_W-1:0]       op = '0;
  logic [SENS_W-1:0]     sensor_value = '0;
  logic [EIDX_W-1:0]     entry_index = '0;
  logic [LEVEL_W-1:0]    entry_level = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PWM_W-1:0]      pwm_level;
  logic                  boost_on;
  logic [LEVEL_W-1:0]    entry_value;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int pending;
  int checked;
  int requests_sent = 0;
  int sender_quiet = 0;
  int stuck_cycles = 0;
  int run_left = 0;
  logic [OP_W-1:0] run_op = OP_INC;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adaptive_brightness_table_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .sensor_value (sensor_value),
    .entry_index  (entry_index),
    .entry_level  (entry_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pwm_level    (pwm_level),
    .boost_on     (boost_on),
    .entry_value  (entry_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  brightness_checker i_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .sensor_value (sensor_value),
    .entry_index  (entry_index),
    .entry_level  (entry_level),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pwm_level    (pwm_level),
    .boost_on     (boost_on),
    .entry_value  (entry_value),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .pending      (pending),
    .checked      (checked)
  );

  // wait before the next request or result: mostly a random gap, with
  // occasional stretches of back-to-back traffic
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      quiet_left = $urandom_range(10, 30);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // entered and left at a falling edge; holds the request until it is taken
  task automatic send_request(
    input logic [OP_W-1:0]    code,
    input logic [SENS_W-1:0]  sens,
    input logic [EIDX_W-1:0]  idx,
    input logic [LEVEL_W-1:0] lvl
  );
    int gap;
    gap = draw_wait(sender_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= code;
    sensor_value <= sens;
    entry_index  <= idx;
    entry_level  <= lvl;
    do @(posedge clk); while (in_stall);
    requests_sent++;
    @(negedge clk);
  endtask

  // registers change only with nothing in flight
  task automatic set_config(input logic [CFG_IDX_W-1:0] idx, input logic val);
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side: random stalls per result, plus one long hold-off so the
  // output register and the request slot both fill and in_stall backs up
  initial begin : result_sink
    int n;
    int taken;
    int quiet;
    taken = 0;
    quiet = 0;
    @(negedge clk);
    forever begin
      n = (taken == HOLD_OFF_AT) ? HOLD_OFF_CYCLES : draw_wait(quiet);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
      @(negedge clk);
    end
  end

  // give up once nothing moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    int p;
    int k;
    int pick;
    logic [OP_W-1:0]    code;
    logic [SENS_W-1:0]  sens;
    logic [LEVEL_W-1:0] lvl;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset setting, auto and boost off: entry 0 serves every sensor, increase and decrease request
    send_request(OP_READ, SENS_W'($urandom), 4'd0, 8'd0);
    send_request(OP_READ, SENS_W'($urandom), 4'd15, 8'd255);
    send_request(OP_LOAD, SENS_W'($urandom), 4'd0, 8'd255);        // clamps to 133
    // 133 drives 99 without boost
    send_request(OP_SENSOR, 10'd1023, EIDX_W'($urandom), LEVEL_W'($urandom));
    // above 99 falls back to 99
    send_request(OP_INC, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_LOAD, 10'd0, 4'd0, 8'd0);
    // floor at zero
    send_request(OP_DEC, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_SPARE_A, 10'h3ff, 4'hf, 8'hff);
    send_request(OP_SPARE_B, 10'h000, 4'h0, 8'h00);
    // no effect, boost off
    send_request(OP_BOOSTOFF, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));

    // boost allowed: levels past 99 raise the boost output
    set_config(CFG_BOOST, 1'b1);
    send_request(OP_LOAD, SENS_W'($urandom), 4'd0, 8'd132);
    // 133, boost on
    send_request(OP_INC, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));
    // ceiling holds
    send_request(OP_INC, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_BOOSTOFF, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_SENSOR, 10'd0, EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_DEC, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));

    // auto mode: sensor picks the entry and every step reshapes the table
    set_config(CFG_AUTO, 1'b1);
    // lowest ambient entry
    send_request(OP_SENSOR, 10'd0, EIDX_W'($urandom), LEVEL_W'($urandom));
    // last entry
    send_request(OP_SENSOR, 10'd1023, EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_SENSOR, 10'd511, EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_INC, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_DEC, SENS_W'($urandom), EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_READ, 10'h3ff, 4'd15, 8'd255);
    send_request(OP_LOAD, SENS_W'($urandom), 4'd15, 8'd133);

    // dropping boost clears the output and caps the drive at 99
    set_config(CFG_BOOST, 1'b0);
    send_request(OP_SENSOR, 10'd1023, EIDX_W'($urandom), LEVEL_W'($urandom));
    send_request(OP_READ, SENS_W'($urandom), 4'd1, LEVEL_W'($urandom));

    // random phases, one auto/boost setting each; increase and decrease come
    // in runs so that levels reach the ceiling and the floor
    for (p = 0; p < PHASES; p++) begin
      set_config(CFG_AUTO, PHASE_AUTO[p]);
      set_config(CFG_BOOST, PHASE_BOOST[p]);
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        if (run_left > 0) begin
          code = run_op;
          run_left--;
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 25)      code = OP_SENSOR;
          else if (pick < 45) code = OP_INC;
          else if (pick < 65) code = OP_DEC;
          else if (pick < 77) code = OP_LOAD;
          else if (pick < 90) code = OP_READ;
          else if (pick < 95) code = OP_BOOSTOFF;
          else                code = $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
          if ((code == OP_INC || code == OP_DEC) && $urandom_range(0, 2) == 0) begin
            run_op   = code;
            run_left = $urandom_range(2, 20);
          end
        end
        case ($urandom_range(0, 7))
          0:       sens = '0;
          1:       sens = '1;
          default: sens = SENS_W'($urandom_range(0, 1023));
        endcase
        // mostly legal levels, some past the clamp point
        lvl = ($urandom_range(0, 3) == 0) ? LEVEL_W'($urandom_range(134, 255))
                                          : LEVEL_W'($urandom_range(0, 133));
        send_request(code, sens, EIDX_W'($urandom_range(0, 15)), lvl);
      end
    end

    // let everything drain, then wait out the drain margin for stray results
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("ran %0d requests, %0d results checked, through all four auto/boost settings",
             requests_sent, checked);
    $display("included a %0d-cycle result stall that backed up the request side",
             HOLD_OFF_CYCLES);
    if (mismatches == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: sim.f
design/abt_pkg.sv
design/abt_step_unit.sv
design/adaptive_brightness_table_top.sv
sim/brightness_checker.sv
sim/adaptive_brightness_table_top_tb.sv
